/* hw/rtl/stab_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stab_pkg
// Shared types, codes and helpers of the station table.
// ----------------------------------------------------------------------------
package stab_pkg;

	// Default table geometry
	localparam int unsigned ENTRIES_DEF = 256;
	localparam int unsigned NODES_DEF   = 16;

	// Field widths of one item and one result
	localparam int unsigned MAC_W   = 48;
	localparam int unsigned NODE_W  = 4;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned SLOT_W  = 8;
	localparam int unsigned COUNT_W = 9;

	// Request modes
	typedef enum logic [1:0] {
		MODE_REPORT  = 2'd0,
		MODE_REFRESH = 2'd1,
		MODE_SETTLE  = 2'd2,
		MODE_FORGET  = 2'd3
	} mode_t;

	// Entry status codes
	localparam logic [1:0] STAT_UNKNOWN = 2'd0;
	localparam logic [1:0] STAT_OFFLINE = 2'd1;
	localparam logic [1:0] STAT_ONLINE  = 2'd2;

	// One table row as held in the RAM
	typedef struct packed {
		logic              valid;
		logic [1:0]        status;
		logic [NODE_W-1:0] node;
		logic [MAC_W-1:0]  mac;
		logic [TIME_W-1:0] seen_stamp;
		logic [TIME_W-1:0] connect;
	} entry_t;

	// Controller states
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_TAIL,
		S_COMMIT
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic clear_we;
		logic start;
		logic scan_rd;
		logic commit;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic out_free;
	} stat_t;

	// Node index reduced modulo the node count for counts of 2 or more (up to 8 subtracts, 4-bit value)
	function automatic logic [NODE_W-1:0] node_mod(input logic [NODE_W-1:0] v,
			input int unsigned nodes);
		logic [NODE_W-1:0] r;
		r = v;
		for (int k = 0; k < 8; k++) begin
			if (int'(r) >= int'(nodes)) begin
				r = r - NODE_W'(nodes);
			end
		end
		return r;
	endfunction

endpackage

/* hw/rtl/station_table_upsert_age_replace.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// station_table_upsert_age_replace
// Station table keyed by MAC address with lookup, insert and replacement of
// the oldest entry that is not online.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one request item: mode,
//   mac_addr, node_id, connect_time, now_time. Output channel
//   (out_valid/out_ready) returns exactly one result item per request.
//   Every request walks the whole table through the single read port of the
//   entry RAM, one entry per cycle, then commits its update.
//   The block works on one item at a time; in_ready is high while idle, even
//   when a finished result still waits in the output register.
//   A stalled receiver holds the result; the next item runs its scan and
//   waits at commit until the output register is free.
//   After reset a clearing pass over all ENTRIES entries zeroes the table; in_ready
//   stays low during that pass.
// ----------------------------------------------------------------------------
module station_table_upsert_age_replace #(
	parameter int unsigned ENTRIES = stab_pkg::ENTRIES_DEF,
	parameter int unsigned NODES   = stab_pkg::NODES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    mode,
	input  logic [stab_pkg::MAC_W-1:0]    mac_addr,
	input  logic [stab_pkg::NODE_W-1:0]   node_id,
	input  logic [stab_pkg::TIME_W-1:0]   connect_time,
	input  logic [stab_pkg::TIME_W-1:0]   now_time,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [stab_pkg::SLOT_W-1:0]   slot,
	output logic                          hit,
	output logic                          inserted,
	output logic                          claimed,
	output logic                          table_full,
	output logic [stab_pkg::COUNT_W-1:0]  online_count
);
	import stab_pkg::*;

	cmd_t                       cmd;
	stat_t                      stat;
	logic [$clog2(ENTRIES)-1:0] addr;

	stab_ctrl #(
		.ENTRIES(ENTRIES)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stat    (stat),
		.cmd     (cmd),
		.addr    (addr)
	);

	stab_dp #(
		.ENTRIES(ENTRIES),
		.NODES  (NODES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.addr        (addr),
		.stat        (stat),
		.mode        (mode),
		.mac_addr    (mac_addr),
		.node_id     (node_id),
		.connect_time(connect_time),
		.now_time    (now_time),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.slot        (slot),
		.hit         (hit),
		.inserted    (inserted),
		.claimed     (claimed),
		.table_full  (table_full),
		.online_count(online_count)
	);

endmodule

/* hw/rtl/stab_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stab_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module stab_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hw/rtl/stab_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stab_ctrl
// Sequencer: clearing pass, table scan, commit of one item.
// ----------------------------------------------------------------------------
module stab_ctrl #(
	parameter int unsigned ENTRIES = stab_pkg::ENTRIES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  stab_pkg::stat_t            stat,
	output stab_pkg::cmd_t             cmd,
	output logic [$clog2(ENTRIES)-1:0] addr
);
	import stab_pkg::*;

	localparam int unsigned IW = $clog2(ENTRIES);
	localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

	state_t        state_q, state_d;
	logic [IW-1:0] cnt_q, cnt_d;

	// State and address counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	assign addr = cnt_q;

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clear_we = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					cnt_d   = '0;
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				cnt_d    = '0;
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_rd = 1'b1;
				cnt_d       = cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					cnt_d   = '0;
					state_d = S_TAIL;
				end
			end
			S_TAIL: begin
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

/* hw/rtl/stab_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stab_dp
// Datapath: table RAM, per-entry scan logic, commit and result register.
// ----------------------------------------------------------------------------
module stab_dp #(
	parameter int unsigned ENTRIES = stab_pkg::ENTRIES_DEF,
	parameter int unsigned NODES   = stab_pkg::NODES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  stab_pkg::cmd_t                cmd,
	input  logic [$clog2(ENTRIES)-1:0]    addr,
	output stab_pkg::stat_t               stat,
	input  logic [1:0]                    mode,
	input  logic [stab_pkg::MAC_W-1:0]    mac_addr,
	input  logic [stab_pkg::NODE_W-1:0]   node_id,
	input  logic [stab_pkg::TIME_W-1:0]   connect_time,
	input  logic [stab_pkg::TIME_W-1:0]   now_time,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [stab_pkg::SLOT_W-1:0]   slot,
	output logic                          hit,
	output logic                          inserted,
	output logic                          claimed,
	output logic                          table_full,
	output logic [stab_pkg::COUNT_W-1:0]  online_count
);
	import stab_pkg::*;

	localparam int unsigned IW = $clog2(ENTRIES);
	localparam int unsigned CW = $clog2(ENTRIES + 1);

	// Captured item
	mode_t             mode_q;
	logic [MAC_W-1:0]  mac_q;
	logic [NODE_W-1:0] node_q;
	logic [TIME_W-1:0] conn_q;
	logic [TIME_W-1:0] now_q;

	// Scan results
	logic              found_q, have_free_q, have_old_q, fhit_q;
	logic [IW-1:0]     sidx_q, fidx_q, oidx_q;
	logic [TIME_W-1:0] old_ls_q;
	entry_t            match_q;
	logic [CW-1:0]     total_q;

	// Read pipeline
	logic          proc_vld_s1;
	logic [IW-1:0] idx_s1;
	entry_t        rd_entry;

	// Result register
	logic               out_valid_q;
	logic [SLOT_W-1:0]  slot_q;
	logic               hit_q, ins_q, clm_q, full_q;
	logic [COUNT_W-1:0] count_q;

	// RAM port signals
	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	entry_t        ram_wdata;

	stab_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(addr),
		.rdata(rd_entry)
	);

	// Per-entry scan decisions on the entry read last cycle
	logic   e_match, e_old, scan_we, forget_dec;
	entry_t scan_wdata;

	always_comb begin
		e_match    = rd_entry.valid && (rd_entry.mac == mac_q);
		e_old      = rd_entry.valid && (rd_entry.status != STAT_ONLINE) &&
			(!have_old_q || (rd_entry.seen_stamp < old_ls_q));
		scan_we    = 1'b0;
		forget_dec = 1'b0;
		scan_wdata = rd_entry;
		case (mode_q)
			MODE_REFRESH: begin
				scan_we           = 1'b1;
				scan_wdata.status = STAT_UNKNOWN;
			end
			MODE_SETTLE: begin
				if (rd_entry.valid && (rd_entry.status == STAT_UNKNOWN) &&
						(rd_entry.node == node_q)) begin
					scan_we           = 1'b1;
					scan_wdata.status = STAT_OFFLINE;
				end
			end
			MODE_FORGET: begin
				if (e_match) begin
					scan_we          = 1'b1;
					scan_wdata.valid = 1'b0;
					forget_dec       = (rd_entry.status == STAT_ONLINE) && (total_q != '0);
				end
			end
			default: begin
			end
		endcase
	end

	// Commit of a report and next counter value
	logic          c_claim, c_ins, c_full, c_inc;
	logic [IW-1:0] c_idx;
	logic [CW-1:0] c_total;
	entry_t        c_entry;

	always_comb begin
		c_claim = 1'b0;
		c_ins   = 1'b0;
		c_full  = 1'b0;
		c_inc   = 1'b0;
		c_idx   = '0;
		c_total = total_q;
		c_entry.valid      = 1'b1;
		c_entry.status     = STAT_ONLINE;
		c_entry.node       = node_q;
		c_entry.mac        = mac_q;
		c_entry.seen_stamp = now_q;
		c_entry.connect    = conn_q;
		case (mode_q)
			MODE_REPORT: begin
				if (found_q) begin
					c_idx   = sidx_q;
					c_inc   = (match_q.status != STAT_ONLINE);
					c_claim = c_inc || ((conn_q != '0) &&
						((match_q.connect == '0) || (conn_q < match_q.connect)));
				end else if (have_free_q || have_old_q) begin
					c_idx   = have_free_q ? fidx_q : oidx_q;
					c_ins   = 1'b1;
					c_claim = 1'b1;
					c_inc   = 1'b1;
				end else begin
					c_full = 1'b1;
				end
				if (c_claim && c_inc) begin
					c_total = total_q + 1'b1;
				end
			end
			MODE_REFRESH: begin
				c_total = '0;
			end
			default: begin
			end
		endcase
	end

	// Write port selection: clearing pass, commit, scan update
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_s1;
		ram_wdata = scan_wdata;
		if (cmd.clear_we) begin
			ram_we    = 1'b1;
			ram_waddr = addr;
			ram_wdata = '0;
		end else if (cmd.commit) begin
			ram_we    = c_claim;
			ram_waddr = c_idx;
			ram_wdata = c_entry;
		end else if (proc_vld_s1) begin
			ram_we = scan_we;
		end
	end

	// Item capture
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			mode_q <= mode_t'(mode);
			mac_q  <= mac_addr;
			node_q <= node_mod(node_id, NODES);
			conn_q <= connect_time;
			now_q  <= now_time;
		end
	end

	// Read pipeline stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proc_vld_s1 <= 1'b0;
		end else begin
			proc_vld_s1 <= cmd.scan_rd;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= addr;
	end

	// Scan flags and online counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q     <= 1'b0;
			have_free_q <= 1'b0;
			have_old_q  <= 1'b0;
			fhit_q      <= 1'b0;
			total_q     <= '0;
		end else if (cmd.start) begin
			found_q     <= 1'b0;
			have_free_q <= 1'b0;
			have_old_q  <= 1'b0;
			fhit_q      <= 1'b0;
		end else if (cmd.commit) begin
			total_q <= c_total;
		end else if (proc_vld_s1) begin
			if (mode_q == MODE_REPORT) begin
				if (e_match && !found_q) begin
					found_q <= 1'b1;
				end
				if (!rd_entry.valid && !have_free_q) begin
					have_free_q <= 1'b1;
				end
				if (e_old && !e_match && !found_q) begin
					have_old_q <= 1'b1;
				end
			end else if (mode_q == MODE_FORGET) begin
				if (e_match) begin
					fhit_q <= 1'b1;
				end
				if (forget_dec) begin
					total_q <= total_q - 1'b1;
				end
			end
		end
	end

	// Scan payload: first match, first free, oldest replaceable
	always_ff @(posedge clk) begin
		if (proc_vld_s1 && (mode_q == MODE_REPORT)) begin
			if (e_match && !found_q) begin
				sidx_q  <= idx_s1;
				match_q <= rd_entry;
			end
			if (!rd_entry.valid && !have_free_q) begin
				fidx_q <= idx_s1;
			end
			if (e_old && !e_match && !found_q) begin
				oidx_q   <= idx_s1;
				old_ls_q <= rd_entry.seen_stamp;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			slot_q  <= (mode_q == MODE_REPORT && !c_full) ? SLOT_W'(c_idx) : '0;
			hit_q   <= (mode_q == MODE_REPORT) ? found_q :
				((mode_q == MODE_FORGET) ? fhit_q : 1'b0);
			ins_q   <= c_ins;
			clm_q   <= c_claim;
			full_q  <= c_full;
			count_q <= COUNT_W'(c_total);
		end
	end

	assign stat.out_free = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign slot          = slot_q;
	assign hit           = hit_q;
	assign inserted      = ins_q;
	assign claimed       = clm_q;
	assign table_full    = full_q;
	assign online_count  = count_q;

endmodule
